/* hdl/arpc_pkg.sv */
// Package for the ARP cache engine: sizes, operation and result codes,
// the item structs of both channels and the structs shared by the controller and the cell row.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    localparam int CACHE_ENTRIES = 32;
    localparam int IDX_W = $clog2(CACHE_ENTRIES);

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_PACKET = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISS    = 2'd1;
    localparam logic [1:0] STAT_DROP    = 2'd2;
    localparam logic [1:0] STAT_IGNORED = 2'd3;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_UPDATED  = 2'd1;
    localparam logic [1:0] ACT_INSERTED = 2'd2;

    localparam logic [15:0] HW_ETHERNET  = 16'h0001;
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN  = 8'd6;
    localparam logic [7:0]  IP_ADDR_LEN  = 8'd4;
    localparam logic [15:0] OPC_REQUEST  = 16'd1;
    localparam logic [10:0] MIN_PKT_LEN  = 11'd28;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  if_index;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [31:0] tgt_ip;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] addr_lengths;
        logic [15:0] arp_opcode;
        logic [10:0] packet_len;
        logic [31:0] local_ip;
        logic [47:0] local_mac;
    } arpc_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  table_action;
        logic [47:0] found_mac;
        logic        reply_valid;
        logic [47:0] reply_dest_mac;
        logic [31:0] reply_dest_ip;
    } arpc_rsp_t;

    typedef struct packed {
        logic        token;
        logic        hit;
        logic [47:0] mac;
    } arpc_link_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [3:0]  iface;
        logic [47:0] mac;
        logic        wr_hit;
        logic        wr_new;
    } arpc_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SCAN,
        ST_FINISH
    } arpc_state_t;

endpackage

`default_nettype wire

/* hdl/arpc_cell.sv */
// One cache entry of the ARP cache row: stored key and MAC, key compare,
// and one stage of the search token path. Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arpc_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire arpc_pkg::arpc_link_t link_in,
    output arpc_pkg::arpc_link_t      link_out,
    input  wire arpc_pkg::arpc_cmd_t  cmd,
    input  wire logic                 slot_sel,
    output logic                      matched
);
    import arpc_pkg::*;

    logic [31:0] ip_reg, ip_next;
    logic [3:0]  if_reg, if_next;
    logic [47:0] mac_reg, mac_next;
    logic        match_reg, match_next;
    arpc_link_t  link_reg, link_next;
    logic        cmp;
    logic        hit_here;
    logic        wr_new;
    logic        wr_upd;

    always_comb
    begin
        cmp      = (ip_reg == cmd.ip) && (if_reg == cmd.iface) && (cmd.ip != 32'd0);
        hit_here = link_in.token && cmp;

        link_next.token = link_in.token;
        link_next.hit   = link_in.hit || hit_here;
        link_next.mac   = hit_here ? mac_reg : link_in.mac;

        match_next = link_in.token ? cmp : match_reg;

        wr_new = cmd.wr_new && slot_sel;
        wr_upd = cmd.wr_hit && match_reg;

        ip_next  = ip_reg;
        if_next  = if_reg;
        mac_next = mac_reg;
        if (wr_new)
        begin
            ip_next  = cmd.ip;
            if_next  = cmd.iface;
            mac_next = cmd.mac;
        end
        else if (wr_upd)
        begin
            mac_next = cmd.mac;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg    <= '0;
            if_reg    <= '0;
            match_reg <= 1'b0;
            link_reg  <= '0;
        end
        else
        begin
            ip_reg    <= ip_next;
            if_reg    <= if_next;
            match_reg <= match_next;
            link_reg  <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg <= mac_next;
    end

    assign link_out = link_reg;
    assign matched  = match_reg;

    // A new entry is only written where no entry of the same key exists.
    a_new_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_new && cmd.wr_hit))
        else $error("cell sees update and insert together");
    // An empty entry never reports a match.
    a_empty_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        link_in.token && (ip_reg == 32'd0) |=> !match_reg)
        else $error("empty entry matched");
    // The token leaves in the cycle after it arrives.
    a_token_moves: assert property (@(posedge clk) disable iff (!rst_n)
        link_in.token |=> link_out.token)
        else $error("token lost in cell");

endmodule

`default_nettype wire

/* hdl/arpc_ctrl.sv */
// Controller of the ARP cache: takes items, launches the search token down the
// cell row, decides the table update and holds the result item. Depends on arpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arpc_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire arpc_pkg::arpc_req_t            req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output arpc_pkg::arpc_rsp_t                 rsp,
    output logic                                launch,
    input  wire arpc_pkg::arpc_link_t           tail,
    output arpc_pkg::arpc_cmd_t                 cmd,
    output logic [arpc_pkg::IDX_W-1:0]          ptr
);
    import arpc_pkg::*;

    arpc_state_t       state_reg, state_next;
    arpc_req_t         item_reg, item_next;
    logic              hit_reg, hit_next;
    logic [47:0]       hmac_reg, hmac_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic              rsp_valid_reg, rsp_valid_next;
    arpc_rsp_t         rsp_reg, rsp_next;
    arpc_rsp_t         result;
    logic              hdr_ok;
    logic              to_me;
    logic              ip_nz;
    logic              want_hit;
    logic              want_new;
    logic              out_free;

    always_comb
    begin
        hdr_ok = (item_reg.packet_len >= MIN_PKT_LEN)
              && (item_reg.hw_type == HW_ETHERNET)
              && (item_reg.proto_type == PROTO_IPV4)
              && (item_reg.addr_lengths[15:8] == HW_ADDR_LEN)
              && (item_reg.addr_lengths[7:0] == IP_ADDR_LEN);
        to_me  = (item_reg.tgt_ip == item_reg.local_ip) && (item_reg.local_ip != 32'd0);
        ip_nz  = (item_reg.ip_addr != 32'd0);

        result   = '0;
        want_hit = 1'b0;
        want_new = 1'b0;
        case (item_reg.operation)
            OP_LOOKUP:
            begin
                if (hit_reg)
                    result.found_mac = hmac_reg;
                else
                    result.status = STAT_MISS;
            end
            OP_INSERT:
            begin
                if (!ip_nz)
                    result.status = STAT_IGNORED;
                else if (hit_reg)
                begin
                    want_hit            = 1'b1;
                    result.table_action = ACT_UPDATED;
                end
                else
                begin
                    want_new            = 1'b1;
                    result.table_action = ACT_INSERTED;
                end
            end
            OP_PACKET:
            begin
                if (!hdr_ok)
                    result.status = STAT_DROP;
                else
                begin
                    if (ip_nz && hit_reg)
                    begin
                        want_hit            = 1'b1;
                        result.table_action = ACT_UPDATED;
                    end
                    else if (ip_nz && to_me)
                    begin
                        want_new            = 1'b1;
                        result.table_action = ACT_INSERTED;
                    end
                    if ((item_reg.arp_opcode == OPC_REQUEST) && to_me)
                    begin
                        result.reply_valid    = 1'b1;
                        result.reply_dest_mac = item_reg.mac_addr;
                        result.reply_dest_ip  = item_reg.ip_addr;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_comb
    begin
        out_free       = !rsp_valid_reg || !rsp_stall;
        state_next     = state_reg;
        item_next      = item_reg;
        hit_next       = hit_reg;
        hmac_next      = hmac_reg;
        ptr_next       = ptr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        req_stall      = 1'b1;
        launch         = 1'b0;
        cmd.ip         = item_reg.ip_addr;
        cmd.iface      = item_reg.if_index;
        cmd.mac        = item_reg.mac_addr;
        cmd.wr_hit     = 1'b0;
        cmd.wr_new     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                launch     = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (tail.token)
                begin
                    hit_next   = tail.hit;
                    hmac_next  = tail.mac;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.wr_hit     = want_hit;
                    cmd.wr_new     = want_new;
                    rsp_next       = result;
                    rsp_valid_next = 1'b1;
                    if (want_new)
                    begin
                        if (ptr_reg == IDX_W'(CACHE_ENTRIES - 1))
                            ptr_next = '0;
                        else
                            ptr_next = ptr_reg + IDX_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        hit_reg  <= hit_next;
        hmac_reg <= hmac_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign ptr       = ptr_reg;

    // The insert slot stays inside the table.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= IDX_W'(CACHE_ENTRIES - 1))
        else $error("insert slot out of range");
    // An update is only issued when the search found the key.
    a_upd_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_hit |-> hit_reg)
        else $error("update without a hit");
    // A launch is always followed by the scan.
    a_launch_scan: assert property (@(posedge clk) disable iff (!rst_n)
        launch |=> (state_reg == ST_SCAN))
        else $error("launch not followed by scan");
    // The pointer moves only when a new entry is written.
    a_ptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.wr_new |=> $stable(ptr_reg))
        else $error("insert slot moved without insert");

endmodule

`default_nettype wire

/* hdl/arp_cache_engine.sv */
// Top level of the ARP cache engine: the controller and a row of CACHE_ENTRIES cells.
// Depends on arpc_pkg, arpc_cell and arpc_ctrl.
//
//   channel | signals                   | direction | item
//   req     | req_valid, req_stall, req | in        | arpc_req_t
//   rsp     | rsp_valid, rsp_stall, rsp | out       | arpc_rsp_t
//
// The result item is loaded into the output register once the search token has moved one cell
// per cycle down the whole row, the search outcome has been taken and the update has been decided.
// The next item is taken when the controller is back in idle, after the result is loaded.
// One item is worked on at a time; the next one is taken while a result still waits.
// Reset clears every entry to empty at once; there is no clearing pass.
// A stalled result holds the update of the next item until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_engine (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire arpc_pkg::arpc_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output arpc_pkg::arpc_rsp_t      rsp
);
    import arpc_pkg::*;

    arpc_link_t                chain [CACHE_ENTRIES+1];
    arpc_cmd_t                 cmd;
    logic                      launch;
    logic [IDX_W-1:0]          ptr;
    logic [CACHE_ENTRIES-1:0]  slot_sel;
    logic [CACHE_ENTRIES-1:0]  match_vec;
    logic [CACHE_ENTRIES-1:0]  token_vec;

    assign chain[0].token = launch;
    assign chain[0].hit   = 1'b0;
    assign chain[0].mac   = '0;

    arpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .launch    (launch),
        .tail      (chain[CACHE_ENTRIES]),
        .cmd       (cmd),
        .ptr       (ptr)
    );

    for (genvar i = 0; i < CACHE_ENTRIES; i++)
    begin : g_cell
        assign slot_sel[i]  = (ptr == IDX_W'(i));
        assign token_vec[i] = chain[i+1].token;

        arpc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (chain[i]),
            .link_out (chain[i+1]),
            .cmd      (cmd),
            .slot_sel (slot_sel[i]),
            .matched  (match_vec[i])
        );
    end

    // Keys in the table are unique, so outside a search at most one entry holds a match.
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        (token_vec == '0) |-> $onehot0(match_vec))
        else $error("more than one entry matched");
    // Only one search token is in the row at a time.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(token_vec))
        else $error("more than one token in the row");
    // No new item is taken while a search is under way.
    a_no_take_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (token_vec != '0) |-> req_stall)
        else $error("item taken during a search");

endmodule

`default_nettype wire
